// ===== sv/dpvu_pkg.sv =====
// Package: word types, register codes and internal bundles for the pair velocity update.
`timescale 1ns / 1ps
`default_nettype none

package dpvu_pkg;

   typedef struct packed {
      logic [31:0] mass_a;
      logic [31:0] mass_b;
      logic [31:0] vel_a_x;
      logic [31:0] vel_a_y;
      logic [31:0] vel_a_z;
      logic [31:0] vel_b_x;
      logic [31:0] vel_b_y;
      logic [31:0] vel_b_z;
      logic [31:0] dir_x;
      logic [31:0] dir_y;
      logic [31:0] dir_z;
      logic [31:0] dissipation_ratio;
   } req_type;

   typedef struct packed {
      logic [31:0] new_a_x;
      logic [31:0] new_a_y;
      logic [31:0] new_a_z;
      logic [31:0] new_b_x;
      logic [31:0] new_b_y;
      logic [31:0] new_b_z;
      logic [1:0]  outcome;
   } rsp_type;

   localparam logic [1:0] OUTCOME_UPDATED   = 2'd0;
   localparam logic [1:0] OUTCOME_ZERO_MASS = 2'd1;
   localparam logic [1:0] OUTCOME_SLOW_PAIR = 2'd2;

   localparam logic [1:0] CSR_EMISSION_COEFF    = 2'd0;
   localparam logic [1:0] CSR_MAX_LOSS_FRACTION = 2'd1;
   localparam logic [1:0] CSR_MIN_REL_SPEED     = 2'd2;

   localparam logic [15:0] EMISSION_COEFF_RESET    = 16'd26214;
   localparam logic [15:0] MAX_LOSS_FRACTION_RESET = 16'd64881;
   localparam logic [31:0] MIN_REL_SPEED_RESET     = 32'd1;

   localparam logic [31:0] RATIO_ONE = 32'h0001_0000;

   // carried alongside the long arithmetic units
   typedef struct packed {
      logic [2:0][31:0] va;
      logic [2:0][31:0] vb;
      logic [2:0][31:0] nmag;
      logic [2:0]       nneg;
      logic [2:0]       dneg;
      logic             zero;
   } byp_type;

   typedef struct packed {
      logic [2:0][31:0] va;
      logic [2:0][31:0] vb;
      logic [2:0][31:0] vcm;
      logic [2:0]       nneg;
      logic [1:0]       outcome;
   } tail_type;

endpackage

`default_nettype wire

// ===== sv/dissipative_pair_velocity_update.sv =====
// Top level: inelastic pair velocity update pipeline with its register file.
// Throughput: one pair per cycle unless a stalled rsp word holds the pipeline;
// depth is set by the 34-stage square root of |va - vb|^2.
// A stalled rsp word freezes every stage; req_stall follows it in the same cycle.
// Reset (synchronous) clears all stage valids and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module dissipative_pair_velocity_update (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dpvu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dpvu_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   import dpvu_pkg::*;

   localparam int UNIT_LAT = 34;

   function automatic logic [31:0] sat32(input logic [38:0] v);
      if (v[38] && !(&v[37:31])) begin
         sat32 = 32'h8000_0000;
      end else if (!v[38] && (|v[37:31])) begin
         sat32 = 32'h7FFF_FFFF;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   logic en;
   logic [15:0] ec_ff;
   logic [15:0] ml_ff;
   logic [31:0] mr_ff;

   // control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, rsp_valid_ff;
   logic [UNIT_LAT-1:0] vu_ff;

   // stage 1
   req_type req_ff;
   logic [31:0] va1 [3];
   logic [31:0] vb1 [3];
   logic [31:0] n1  [3];

   // stage 2
   logic [32:0] mag2_ff [3];
   logic [32:0] mag2_in [3];
   logic [31:0] ma2_ff, mb2_ff;
   logic [32:0] m2_ff, m2_in;
   logic [47:0] fprod2_ff, fprod2_in;
   byp_type     byp2_ff, byp2_in;

   // stage 3
   logic [64:0] sq3_ff [3];
   logic [64:0] sq3_in [3];
   logic [64:0] tp3_ff [3];
   logic [64:0] tp3_in [3];
   logic [15:0] f3_ff, f3_in;
   logic [31:0] ma3_ff, mb3_ff;
   logic [32:0] m3_ff;
   byp_type     byp3_ff;

   // stage 4
   logic [65:0] sum4_ff, sum4_in;
   logic [32:0] xs4_ff, xs4_in;
   logic [64:0] tp4_ff [3];
   logic [31:0] ma4_ff, mb4_ff;
   logic [32:0] m4_ff;
   byp_type     byp4_ff;

   // unit outputs
   logic [33:0] vrel_u;
   logic [16:0] s_raw, s_u;
   logic [30:0] wa_raw, wb_raw, wa_u, wb_u;
   logic [32:0] t_raw [3];
   logic [32:0] t_u   [3];
   byp_type     byp_u;

   // stage 5
   logic [33:0] vnew5_ff, vnew5_in;
   logic [50:0] vprod;
   logic [30:0] wa5_ff, wb5_ff;
   logic [31:0] nmag5_ff [3];
   tail_type    tail5_ff, tail5_in;

   // stage 6
   logic [35:0] u6_ff [3];
   logic [35:0] u6_in [3];
   logic [30:0] wa6_ff, wb6_ff;
   tail_type    tail6_ff;

   // stage 7
   logic [36:0] da7_ff [3];
   logic [36:0] db7_ff [3];
   logic [36:0] da7_in [3];
   logic [36:0] db7_in [3];
   tail_type    tail7_ff;

   // output
   rsp_type rsp_ff, rsp_in;
   logic [31:0] na [3];
   logic [31:0] nb [3];

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ec_ff <= EMISSION_COEFF_RESET;
         ml_ff <= MAX_LOSS_FRACTION_RESET;
         mr_ff <= MIN_REL_SPEED_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EMISSION_COEFF:    ec_ff <= csr_wdata[15:0];
            CSR_MAX_LOSS_FRACTION: ml_ff <= csr_wdata[15:0];
            CSR_MIN_REL_SPEED:     mr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         vu_ff        <= '0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         vu_ff        <= {vu_ff[UNIT_LAT-2:0], v4_ff};
         v5_ff        <= vu_ff[UNIT_LAT-1];
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         rsp_valid_ff <= v7_ff;
      end
   end

   assign va1[0] = req_ff.vel_a_x;
   assign va1[1] = req_ff.vel_a_y;
   assign va1[2] = req_ff.vel_a_z;
   assign vb1[0] = req_ff.vel_b_x;
   assign vb1[1] = req_ff.vel_b_y;
   assign vb1[2] = req_ff.vel_b_z;
   assign n1[0]  = req_ff.dir_x;
   assign n1[1]  = req_ff.dir_y;
   assign n1[2]  = req_ff.dir_z;

   always_comb begin
      logic [32:0] dv;
      logic [31:0] excess;
      for (int k = 0; k < 3; k++) begin
         dv              = {va1[k][31], va1[k]} - {vb1[k][31], vb1[k]};
         mag2_in[k]      = dv[32] ? (33'd0 - dv) : dv;
         byp2_in.va[k]   = va1[k];
         byp2_in.vb[k]   = vb1[k];
         byp2_in.nmag[k] = n1[k][31] ? (32'd0 - n1[k]) : n1[k];
         byp2_in.nneg[k] = n1[k][31];
         byp2_in.dneg[k] = dv[32];
      end
      m2_in        = 33'(req_ff.mass_a) + 33'(req_ff.mass_b);
      byp2_in.zero = (m2_in == 33'd0);
      excess       = (req_ff.dissipation_ratio > RATIO_ONE) ?
                     (req_ff.dissipation_ratio - RATIO_ONE) : 32'd0;
      fprod2_in    = 48'(excess) * 48'(ec_ff);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq3_in[k] = 65'(mag2_ff[k]) * 65'(mag2_ff[k]);
         tp3_in[k] = 65'(ma2_ff) * 65'(mag2_ff[k]);
      end
      f3_in = (fprod2_ff[47:16] > 32'(ml_ff)) ? ml_ff : fprod2_ff[31:16];
   end

   assign sum4_in = 66'(sq3_ff[0]) + 66'(sq3_ff[1]) + 66'(sq3_ff[2]);
   assign xs4_in  = {17'h1_0000 - {1'b0, f3_ff}, 16'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         req_ff    <= req_data;
         mag2_ff   <= mag2_in;
         ma2_ff    <= req_ff.mass_a;
         mb2_ff    <= req_ff.mass_b;
         m2_ff     <= m2_in;
         fprod2_ff <= fprod2_in;
         byp2_ff   <= byp2_in;
         sq3_ff    <= sq3_in;
         tp3_ff    <= tp3_in;
         f3_ff     <= f3_in;
         ma3_ff    <= ma2_ff;
         mb3_ff    <= mb2_ff;
         m3_ff     <= m2_ff;
         byp3_ff   <= byp2_ff;
         sum4_ff   <= sum4_in;
         xs4_ff    <= xs4_in;
         tp4_ff    <= tp3_ff;
         ma4_ff    <= ma3_ff;
         mb4_ff    <= mb3_ff;
         m4_ff     <= m3_ff;
         byp4_ff   <= byp3_ff;
      end
   end

   dpvu_sqrt #(.IW(66), .RW(34)) u_sqrt_rel (
      .clock(clock), .en(en), .rad(sum4_ff), .root(vrel_u)
   );

   dpvu_sqrt #(.IW(33), .RW(17)) u_sqrt_loss (
      .clock(clock), .en(en), .rad(xs4_ff), .root(s_raw)
   );

   dpvu_delay #(.W(17), .N(UNIT_LAT - 17)) u_dly_loss (
      .clock(clock), .en(en), .din(s_raw), .dout(s_u)
   );

   dpvu_div #(.NW(62), .DW(33), .QW(31)) u_div_wa (
      .clock(clock), .en(en), .num({ma4_ff, 30'd0}), .den(m4_ff), .quo(wa_raw)
   );

   dpvu_div #(.NW(62), .DW(33), .QW(31)) u_div_wb (
      .clock(clock), .en(en), .num({mb4_ff, 30'd0}), .den(m4_ff), .quo(wb_raw)
   );

   dpvu_delay #(.W(31), .N(UNIT_LAT - 31)) u_dly_wa (
      .clock(clock), .en(en), .din(wa_raw), .dout(wa_u)
   );

   dpvu_delay #(.W(31), .N(UNIT_LAT - 31)) u_dly_wb (
      .clock(clock), .en(en), .din(wb_raw), .dout(wb_u)
   );

   for (genvar k = 0; k < 3; k++) begin : g_axis
      dpvu_div #(.NW(65), .DW(33), .QW(33)) u_div_t (
         .clock(clock), .en(en), .num(tp4_ff[k]), .den(m4_ff), .quo(t_raw[k])
      );

      dpvu_delay #(.W(33), .N(UNIT_LAT - 33)) u_dly_t (
         .clock(clock), .en(en), .din(t_raw[k]), .dout(t_u[k])
      );
   end

   dpvu_delay #(.W($bits(byp_type)), .N(UNIT_LAT)) u_dly_byp (
      .clock(clock), .en(en), .din(byp4_ff), .dout(byp_u)
   );

   assign vprod    = 51'(vrel_u) * 51'(s_u);
   assign vnew5_in = vprod[49:16];

   always_comb begin
      logic [33:0] vbx;
      logic [33:0] tx;
      logic [33:0] c;
      for (int k = 0; k < 3; k++) begin
         vbx              = {{2{byp_u.vb[k][31]}}, byp_u.vb[k]};
         tx               = {1'b0, t_u[k]};
         c                = byp_u.dneg[k] ? (vbx - tx) : (vbx + tx);
         tail5_in.vcm[k]  = c[31:0];
         tail5_in.va[k]   = byp_u.va[k];
         tail5_in.vb[k]   = byp_u.vb[k];
         tail5_in.nneg[k] = byp_u.nneg[k];
      end
      if (byp_u.zero) begin
         tail5_in.outcome = OUTCOME_ZERO_MASS;
      end else if (vrel_u < 34'(mr_ff)) begin
         tail5_in.outcome = OUTCOME_SLOW_PAIR;
      end else begin
         tail5_in.outcome = OUTCOME_UPDATED;
      end
   end

   always_comb begin
      logic [65:0] p;
      for (int k = 0; k < 3; k++) begin
         p        = 66'(vnew5_ff) * 66'(nmag5_ff[k]);
         u6_in[k] = p[65:30];
      end
   end

   always_comb begin
      logic [66:0] pa;
      logic [66:0] pb;
      for (int k = 0; k < 3; k++) begin
         pa        = 67'(u6_ff[k]) * 67'(wb6_ff);
         pb        = 67'(u6_ff[k]) * 67'(wa6_ff);
         da7_in[k] = pa[66:30];
         db7_in[k] = pb[66:30];
      end
   end

   always_comb begin
      logic [38:0] cx;
      logic [38:0] dax;
      logic [38:0] dbx;
      for (int k = 0; k < 3; k++) begin
         cx  = {{7{tail7_ff.vcm[k][31]}}, tail7_ff.vcm[k]};
         dax = {2'b00, da7_ff[k]};
         dbx = {2'b00, db7_ff[k]};
         if (tail7_ff.outcome != OUTCOME_UPDATED) begin
            na[k] = tail7_ff.va[k];
            nb[k] = tail7_ff.vb[k];
         end else if (tail7_ff.nneg[k]) begin
            na[k] = sat32(cx - dax);
            nb[k] = sat32(cx + dbx);
         end else begin
            na[k] = sat32(cx + dax);
            nb[k] = sat32(cx - dbx);
         end
      end
      rsp_in.new_a_x = na[0];
      rsp_in.new_a_y = na[1];
      rsp_in.new_a_z = na[2];
      rsp_in.new_b_x = nb[0];
      rsp_in.new_b_y = nb[1];
      rsp_in.new_b_z = nb[2];
      rsp_in.outcome = tail7_ff.outcome;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vnew5_ff <= vnew5_in;
         wa5_ff   <= wa_u;
         wb5_ff   <= wb_u;
         nmag5_ff <= '{byp_u.nmag[0], byp_u.nmag[1], byp_u.nmag[2]};
         tail5_ff <= tail5_in;
         u6_ff    <= u6_in;
         wa6_ff   <= wa5_ff;
         wb6_ff   <= wb5_ff;
         tail6_ff <= tail5_ff;
         da7_ff   <= da7_in;
         db7_ff   <= db7_in;
         tail7_ff <= tail6_ff;
         rsp_ff   <= rsp_in;
      end
   end

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled rsp word");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted req word not held in first stage");

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.outcome == OUTCOME_UPDATED ||
                     rsp_data.outcome == OUTCOME_ZERO_MASS ||
                     rsp_data.outcome == OUTCOME_SLOW_PAIR))
      else $error("rsp word carries an unused outcome code");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      (v7_ff && rsp_valid && rsp_stall) |=> v7_ff)
      else $error("stage word lost while output stalled");

endmodule

`default_nettype wire

// ===== sv/dpvu_delay.sv =====
// Enabled shift line that aligns a word with the pipelined arithmetic units.
`timescale 1ns / 1ps
`default_nettype none

module dpvu_delay #(
   parameter int W = 32,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] tap_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < N; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[N-1];

endmodule

`default_nettype wire

// ===== sv/dpvu_sqrt.sv =====
// Pipelined floor square root, one root bit per register stage.
`timescale 1ns / 1ps
`default_nettype none

module dpvu_sqrt #(
   parameter int IW = 66,
   parameter int RW = 34
) (
   input  logic          clock,
   input  logic          en,
   input  logic [IW-1:0] rad,
   output logic [RW-1:0] root
);

   localparam int XW = 2 * RW;
   localparam int MW = RW + 4;

   logic [XW-1:0]   x_ff    [RW];
   logic [RW+1:0]   rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [XW-1:0]   x_in    [RW];
   logic [RW+1:0]   rem_in  [RW];
   logic [RW-1:0]   root_in [RW];

   always_comb begin
      logic [XW-1:0] xp;
      logic [RW+1:0] rp;
      logic [RW-1:0] qp;
      logic [MW-1:0] rem_sh;
      logic [MW-1:0] trial;
      logic          ge;
      for (int i = 0; i < RW; i++) begin
         if (i == 0) begin
            xp = XW'(rad);
            rp = '0;
            qp = '0;
         end else begin
            xp = x_ff[i-1];
            rp = rem_ff[i-1];
            qp = root_ff[i-1];
         end
         rem_sh     = {rp, xp[XW-1 -: 2]};
         trial      = MW'({qp, 2'b01});
         ge         = (rem_sh >= trial);
         rem_in[i]  = ge ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
         x_in[i]    = xp << 2;
         root_in[i] = {qp[RW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff[RW-1];

endmodule

`default_nettype wire

// ===== sv/dpvu_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none

module dpvu_div #(
   parameter int NW = 62,
   parameter int DW = 33,
   parameter int QW = 31
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   logic [QW-1:0] n_ff   [QW];
   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] q_ff   [QW];
   logic [DW-1:0] d_ff   [QW];
   logic [QW-1:0] n_in   [QW];
   logic [DW-1:0] rem_in [QW];
   logic [QW-1:0] q_in   [QW];
   logic [DW-1:0] d_in   [QW];

   // quotient must fit QW bits: the upper numerator part starts below den
   always_comb begin
      logic [QW-1:0] np;
      logic [DW-1:0] rp;
      logic [QW-1:0] qp;
      logic [DW-1:0] dp;
      logic [DW:0]   r2;
      logic          ge;
      for (int i = 0; i < QW; i++) begin
         if (i == 0) begin
            np = num[QW-1:0];
            rp = DW'(num[NW-1:QW]);
            qp = '0;
            dp = den;
         end else begin
            np = n_ff[i-1];
            rp = rem_ff[i-1];
            qp = q_ff[i-1];
            dp = d_ff[i-1];
         end
         r2        = {rp, np[QW-1]};
         ge        = (r2 >= {1'b0, dp});
         rem_in[i] = ge ? DW'(r2 - {1'b0, dp}) : DW'(r2);
         n_in[i]   = np << 1;
         q_in[i]   = {qp[QW-2:0], ge};
         d_in[i]   = dp;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff   <= n_in;
         rem_ff <= rem_in;
         q_ff   <= q_in;
         d_ff   <= d_in;
      end
   end

   assign quo = q_ff[QW-1];

endmodule

`default_nettype wire
